// File: hw/rtl/mrpt_pkg.sv
package mrpt_pkg;

  localparam int WitnessTableSize = 12;
  localparam int SmallOddLimit    = 9;

  // Fixed witnesses, in test order.
  function automatic logic [5:0] witness_at(input logic [3:0] idx);
    logic [5:0] w;
    unique case (idx)
      4'd0:    w = 6'd2;
      4'd1:    w = 6'd3;
      4'd2:    w = 6'd5;
      4'd3:    w = 6'd7;
      4'd4:    w = 6'd11;
      4'd5:    w = 6'd13;
      4'd6:    w = 6'd17;
      4'd7:    w = 6'd19;
      4'd8:    w = 6'd23;
      4'd9:    w = 6'd29;
      4'd10:   w = 6'd31;
      4'd11:   w = 6'd37;
      default: w = 6'd2;
    endcase
    return w;
  endfunction

  // Request to the shared modular unit.
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_RED = 2'd1
  } mrpt_op_t;

endpackage

// File: hw/rtl/mrpt_modunit.sv
module mrpt_modunit #(
  parameter int WORD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  mrpt_pkg::mrpt_op_t             op,
  input  logic [WORD_BITS-1:0]           x,
  input  logic [WORD_BITS-1:0]           y,
  input  logic [WORD_BITS-1:0]           m,
  output logic                           done,
  output logic [WORD_BITS-1:0]           result
);
  import mrpt_pkg::*;

  localparam int CntW = $clog2(WORD_BITS + 1);

  // OP_MUL: acc = x*y mod m, scanning y from the top bit.
  // OP_RED: acc = y mod m, shifting y in one bit a step (x is ignored).
  logic                 busy;
  mrpt_op_t             op_q;
  logic [WORD_BITS-1:0] acc, xq, yq, mq;
  logic [CntW-1:0]      cnt;
  logic [WORD_BITS:0]   dbl, dbl_red, sum, sum_red;
  logic [WORD_BITS-1:0] step1, step2;

  always_comb begin
    // Doubling (with a shifted-in bit for reduction), then reduce once.
    dbl     = {acc, (op_q == OP_RED) ? yq[WORD_BITS-1] : 1'b0};
    dbl_red = (dbl >= {1'b0, mq}) ? dbl - {1'b0, mq} : dbl;
    step1   = dbl_red[WORD_BITS-1:0];
    sum     = {1'b0, step1} + {1'b0, xq};
    sum_red = (sum >= {1'b0, mq}) ? sum - {1'b0, mq} : sum;
    step2   = (op_q == OP_MUL && yq[WORD_BITS-1]) ? sum_red[WORD_BITS-1:0] : step1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CntW'(WORD_BITS);
        acc  <= '0;
        xq   <= x;
        yq   <= y;
        mq   <= m;
        op_q <= op;
      end else if (busy) begin
        acc <= step2;
        yq  <= yq << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = acc;

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

  property p_result_reduced;
    @(posedge clk) disable iff (rst) done |-> (result < mq);
  endproperty
  a_result_reduced: assert property (p_result_reduced) else $error("result not reduced");

  property p_no_start_busy;
    @(posedge clk) disable iff (rst) (busy && cnt != CntW'(1)) |=> busy;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("unit stopped early");

endmodule

// File: hw/rtl/miller_rabin_prime_test_64.sv
// Tests one unsigned word for primality with a deterministic Miller-Rabin
// test over the witnesses 2 to 37, and returns one flag word per candidate.
// One candidate is worked at a time; stall on the input stays high until its
// flag is taken. All arithmetic runs through one bit-serial modular unit.
// Small or even numbers are settled in S_CHECK without the unit; others run
// up to WITNESS_COUNT witness rounds, each a modular exponentiation.
module miller_rabin_prime_test_64 #(
  parameter int WORD_BITS     = 64,
  parameter int WITNESS_COUNT = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          candidate,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 prime_flag
);
  import mrpt_pkg::*;

  localparam int WCount = (WITNESS_COUNT > WitnessTableSize) ? WitnessTableSize
                                                             : WITNESS_COUNT;
  localparam int RW     = $clog2(WORD_BITS + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_RED    = 11'b00000000100,
    S_WSTART = 11'b00000001000,
    S_PMUL   = 11'b00000010000,
    S_PSQR   = 11'b00000100000,
    S_PNEXT  = 11'b00001000000,
    S_TEST   = 11'b00010000000,
    S_SQR    = 11'b00100000000,
    S_WEND   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t               state, state_next;
  logic [WORD_BITS-1:0] n, nm1, d, e, base, acc;
  logic [RW-1:0]        r, sq;
  logic [3:0]           widx;
  logic                 flag;
  logic                 unit_start, unit_done;
  mrpt_op_t             unit_op;
  logic [WORD_BITS-1:0] unit_x, unit_y, unit_res;
  logic [WORD_BITS-1:0] wval;
  logic                 issued;
  logic [WORD_BITS-1:0] n_in;

  assign wval = WORD_BITS'(witness_at(widx));

  mrpt_modunit #(.WORD_BITS(WORD_BITS)) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .op     (unit_op),
    .x      (unit_x),
    .y      (unit_y),
    .m      (n),
    .done   (unit_done),
    .result (unit_res)
  );

  // Unit request per state; start is raised only while a calling state has not yet issued.
  always_comb begin
    unit_start = 1'b0;
    unit_op    = OP_MUL;
    unit_x     = acc;
    unit_y     = base;
    unique case (state)
      S_RED:   begin unit_start = !issued; unit_op = OP_RED; unit_y = wval; end
      S_PMUL:  begin unit_start = !issued; end
      S_PSQR:  begin unit_start = !issued; unit_x = base; end
      S_SQR:   begin unit_start = !issued; unit_y = acc; end
      default: ;
    endcase
  end

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign prime_flag = flag;

  // Sequencer. A calling state issues one request to the unit, then the issued
  // bit holds it waiting until the unit reports done.
  assign n_in = candidate[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          n     <= n_in;
          nm1   <= n_in - 1'b1;
          state <= S_CHECK;
        end
        S_CHECK: begin
          widx <= '0;
          // Odd part of n-1 found bitwise below, one shift a cycle.
          d    <= nm1;
          r    <= '0;
          if (n < WORD_BITS'(2)) begin flag <= 1'b0; state <= S_OUT; end
          else if (n == WORD_BITS'(2)) begin flag <= 1'b1; state <= S_OUT; end
          else if (!n[0]) begin flag <= 1'b0; state <= S_OUT; end
          else if (n < WORD_BITS'(SmallOddLimit)) begin flag <= 1'b1; state <= S_OUT; end
          else state <= S_WSTART;
        end
        S_WSTART: begin
          // Strip factors of two from n-1 first (done once, d reused).
          if (!d[0]) begin
            d <= d >> 1;
            r <= r + 1'b1;
          end else begin
            state <= S_RED;
          end
        end
        S_RED: begin
          if (!issued) issued <= 1'b1;
          else if (unit_done) begin
            issued <= 1'b0;
            if (unit_res == '0) begin
              // n divides the witness: passes only if n equals it.
              if (n == wval) begin flag <= 1'b1; state <= S_OUT; end
              else begin flag <= 1'b0; state <= S_OUT; end
            end else begin
              base  <= unit_res;
              acc   <= WORD_BITS'(1);
              e     <= d;
              state <= S_PNEXT;
            end
          end
        end
        S_PNEXT: begin
          if (e == '0) begin
            sq    <= RW'(1);
            state <= S_TEST;
          end else if (e[0]) state <= S_PMUL;
          else state <= S_PSQR;
        end
        S_PMUL: begin
          if (!issued) issued <= 1'b1;
          else if (unit_done) begin
            issued <= 1'b0;
            acc    <= unit_res;
            state  <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (!issued) issued <= 1'b1;
          else if (unit_done) begin
            issued <= 1'b0;
            base   <= unit_res;
            e      <= e >> 1;
            state  <= S_PNEXT;
          end
        end
        S_TEST: begin
          if (acc == WORD_BITS'(1) || acc == nm1) state <= S_WEND;
          else if (sq < r) state <= S_SQR;
          else begin flag <= 1'b0; state <= S_OUT; end
        end
        S_SQR: begin
          if (!issued) issued <= 1'b1;
          else if (unit_done) begin
            issued <= 1'b0;
            sq     <= sq + 1'b1;
            if (unit_res == nm1) state <= S_WEND;
            else begin
              acc   <= unit_res;
              state <= (sq + 1'b1 < r) ? S_SQR : S_TEST;
              if (!(sq + 1'b1 < r)) acc <= WORD_BITS'(2);
            end
          end
        end
        S_WEND: begin
          if (widx == 4'(WCount - 1)) begin flag <= 1'b1; state <= S_OUT; end
          else begin widx <= widx + 1'b1; state <= S_RED; end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // The acc==2 marker above falls into S_TEST only when squarings ran out;
  // 2 is neither 1 nor n-1 for n>=9 and sq>=r, so the round fails.

  property p_out_holds;
    @(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid && $stable(prime_flag);
  endproperty
  a_out_holds: assert property (p_out_holds) else $error("output word changed while stalled");

  property p_busy_stalls;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> in_stall;
  endproperty
  a_busy_stalls: assert property (p_busy_stalls) else $error("input open while busy");

  property p_start_from_idle;
    @(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> (state == S_CHECK);
  endproperty
  a_start_from_idle: assert property (p_start_from_idle) else $error("accepted word lost");

endmodule
